// ===== design/centered_text_bar_pixel_generator_macros.svh =====
// ---------------------------------------------------------------------------
// Text bar rasteriser assertion macros
// Concurrent assertion helpers; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef CENTERED_TEXT_BAR_PIXEL_GENERATOR_MACROS_SVH
`define CENTERED_TEXT_BAR_PIXEL_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset
`define CTB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled in reset
`define CTB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CTB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define CTB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== design/ctb_pkg.sv =====
// ---------------------------------------------------------------------------
// Text bar rasteriser package
// Widths, register codes, reset values, carried structs and the 5x7 font.
// ---------------------------------------------------------------------------
package ctb_pkg;

  localparam int MAX_CHARS_DEF = 64;

  localparam int X_W        = 9;
  localparam int Y_W        = 8;
  localparam int SCALE_W    = 4;
  localparam int LEN_W      = 7;
  localparam int COLOR_W    = 16;
  localparam int CODE_W     = 8;
  localparam int IDX_W      = 6;
  localparam int CELLW_W    = 7;   // 6 * 15 fits
  localparam int WIDTH_W    = 14;  // 127 * 90 fits
  localparam int START_W    = 10;
  localparam int END_W      = WIDTH_W + 1;
  localparam int QUO_W      = 7;   // 511 / 6 fits
  localparam int DIV_W      = X_W + QUO_W;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DATA_IN_W  = 32;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;

  localparam logic [CODE_W-1:0] CODE_FIRST = 8'h20;
  localparam logic [CODE_W-1:0] CODE_LAST  = 8'h7E;
  localparam logic [CODE_W-1:0] CODE_SUBST = 8'h3F;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BAR_LEFT    = 3'd0,
    CFG_BAR_SPAN    = 3'd1,
    CFG_TEXT_TOP    = 3'd2,
    CFG_GLYPH_SCALE = 3'd3,
    CFG_TEXT_LENGTH = 3'd4,
    CFG_INK_COLOR   = 3'd5,
    CFG_PAPER_COLOR = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [X_W-1:0]     bar_left;
    logic [X_W-1:0]     bar_span;
    logic [Y_W-1:0]     text_top;
    logic [SCALE_W-1:0] glyph_scale;
    logic [LEN_W-1:0]   text_length;
    logic [COLOR_W-1:0] ink_color;
    logic [COLOR_W-1:0] paper_color;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    bar_left:    9'd4,
    bar_span:    9'd312,
    text_top:    8'd191,
    glyph_scale: 4'd2,
    text_length: 7'd0,
    ink_color:   16'hFFFF,
    paper_color: 16'h0000
  };

  // Per-item sideband that travels with the divider
  typedef struct packed {
    logic               pix;
    logic               ok;
    logic [ROW_W-1:0]   row;
    logic [SCALE_W-1:0] scale;
    logic [LEN_W-1:0]   len;
    logic [CELLW_W-1:0] cellw;
    logic [IDX_W-1:0]   idx;
    logic [CODE_W-1:0]  code;
  } side_t;

  // Five column bytes, leftmost column in the top byte, bit 0 = top row
  typedef logic [8*GLYPH_COLS-1:0] glyph_t;

  function automatic glyph_t font_glyph(input logic [6:0] gi);
    glyph_t g;
    case (gi)
      7'd0:  g = 40'h0000000000;
      7'd1:  g = 40'h00005F0000;
      7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147F147F14;
      7'd4:  g = 40'h242A7F2A12;
      7'd5:  g = 40'h2313086462;
      7'd6:  g = 40'h3649552250;
      7'd7:  g = 40'h0005030000;
      7'd8:  g = 40'h001C224100;
      7'd9:  g = 40'h0041221C00;
      7'd10: g = 40'h14083E0814;
      7'd11: g = 40'h08083E0808;
      7'd12: g = 40'h0050300000;
      7'd13: g = 40'h0808080808;
      7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402;
      7'd16: g = 40'h3E5149453E;
      7'd17: g = 40'h00427F4000;
      7'd18: g = 40'h4261514946;
      7'd19: g = 40'h2141454B31;
      7'd20: g = 40'h1814127F10;
      7'd21: g = 40'h2745454539;
      7'd22: g = 40'h3C4A494930;
      7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936;
      7'd25: g = 40'h064949291E;
      7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000;
      7'd28: g = 40'h0814224100;
      7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0041221408;
      7'd31: g = 40'h0201510906;
      7'd32: g = 40'h324979413E;
      7'd33: g = 40'h7E1111117E;
      7'd34: g = 40'h7F49494936;
      7'd35: g = 40'h3E41414122;
      7'd36: g = 40'h7F4141221C;
      7'd37: g = 40'h7F49494941;
      7'd38: g = 40'h7F09090901;
      7'd39: g = 40'h3E4149497A;
      7'd40: g = 40'h7F0808087F;
      7'd41: g = 40'h00417F4100;
      7'd42: g = 40'h2040413F01;
      7'd43: g = 40'h7F08142241;
      7'd44: g = 40'h7F40404040;
      7'd45: g = 40'h7F020C027F;
      7'd46: g = 40'h7F0408107F;
      7'd47: g = 40'h3E4141413E;
      7'd48: g = 40'h7F09090906;
      7'd49: g = 40'h3E4151215E;
      7'd50: g = 40'h7F09192946;
      7'd51: g = 40'h4649494931;
      7'd52: g = 40'h01017F0101;
      7'd53: g = 40'h3F4040403F;
      7'd54: g = 40'h1F2040201F;
      7'd55: g = 40'h3F4038403F;
      7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807;
      7'd58: g = 40'h6151494543;
      7'd59: g = 40'h007F414100;
      7'd60: g = 40'h0204081020;
      7'd61: g = 40'h0041417F00;
      7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040;
      7'd64: g = 40'h0001020400;
      7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7F48444438;
      7'd67: g = 40'h3844444420;
      7'd68: g = 40'h384444487F;
      7'd69: g = 40'h3854545418;
      7'd70: g = 40'h087E090102;
      7'd71: g = 40'h0C5252523E;
      7'd72: g = 40'h7F08040478;
      7'd73: g = 40'h00447D4000;
      7'd74: g = 40'h2040443D00;
      7'd75: g = 40'h7F10284400;
      7'd76: g = 40'h00417F4000;
      7'd77: g = 40'h7C04180478;
      7'd78: g = 40'h7C08040478;
      7'd79: g = 40'h3844444438;
      7'd80: g = 40'h7C14141408;
      7'd81: g = 40'h081414187C;
      7'd82: g = 40'h7C08040408;
      7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043F444020;
      7'd85: g = 40'h3C4040207C;
      7'd86: g = 40'h1C2040201C;
      7'd87: g = 40'h3C4030403C;
      7'd88: g = 40'h4428102844;
      7'd89: g = 40'h0C5050503C;
      7'd90: g = 40'h4464544C44;
      7'd91: g = 40'h0008364100;
      7'd92: g = 40'h00007F0000;
      7'd93: g = 40'h0041360800;
      7'd94: g = 40'h08082A1C08;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== design/centered_text_bar_pixel_generator.sv =====
// ---------------------------------------------------------------------------
// Centred text bar pixel generator
// Rasterises a line of 5x7 font text, centred and scaled, into RGB565.
// ---------------------------------------------------------------------------
// Input items arrive on s_axis: tuser = 0 stores tdata's char_code at
// char_index in the text buffer and gives no result; tuser = 1 asks for the
// colour at (pixel_x, pixel_y) and gives one result item on m_axis
// (tdata = colour, tuser = glyph hit). Results leave in request order.
// Registers must be set through cfg_we_i / cfg_addr_i / cfg_wdata_i only while the
// block is idle; the block itself does not enforce this. They take effect at the next item.
// One item is taken per cycle while s_axis_tready is high. A pixel request passes
// through three placement stages, seven divider stages (one quotient bit each),
// the text buffer read and the output register before it is offered on
// m_axis.
// Buffer writes and reads share one stage, so a pixel always sees every
// write taken before it and none after it.
// Reset returns registers to their defaults and empties the pipeline; the
// text buffer keeps no reset value and must be written before it is drawn.
// When m_axis stalls, one result is held in the output register and one
// in a skid register; with the skid full the whole pipeline holds and
// s_axis_tready drops.
// ---------------------------------------------------------------------------
`include "centered_text_bar_pixel_generator_macros.svh"

module centered_text_bar_pixel_generator import ctb_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [5:0] char_index, [13:6] char_code, [22:14] pixel_x, [30:23] pixel_y
  input  logic [DATA_IN_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                  s_axis_tuser,
  // Result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] pixel_color
  output logic [COLOR_W-1:0]    m_axis_tdata,
  // [0] glyph_hit
  output logic                  m_axis_tuser,
  // Register writes
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int ADDR_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_BAR_LEFT:    cfg_q.bar_left    <= cfg_wdata_i[X_W-1:0];
        CFG_BAR_SPAN:    cfg_q.bar_span    <= cfg_wdata_i[X_W-1:0];
        CFG_TEXT_TOP:    cfg_q.text_top    <= cfg_wdata_i[Y_W-1:0];
        CFG_GLYPH_SCALE: cfg_q.glyph_scale <= cfg_wdata_i[SCALE_W-1:0];
        CFG_TEXT_LENGTH: cfg_q.text_length <= cfg_wdata_i[LEN_W-1:0];
        CFG_INK_COLOR:   cfg_q.ink_color   <= cfg_wdata_i[COLOR_W-1:0];
        CFG_PAPER_COLOR: cfg_q.paper_color <= cfg_wdata_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: hold everything once the skid register is occupied
  logic skd_vld_q;
  logic pipe_en;
  logic in_acc;

  assign pipe_en       = !skd_vld_q;
  assign s_axis_tready = pipe_en;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  logic            fe_vld;
  logic [X_W-1:0]  fe_dx;
  side_t           fe_side;

  ctb_front #(
    .MAX_CHARS(MAX_CHARS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (in_acc),
    .pix_i  (s_axis_tuser),
    .idx_i  (s_axis_tdata[5:0]),
    .code_i (s_axis_tdata[13:6]),
    .x_i    (s_axis_tdata[22:14]),
    .y_i    (s_axis_tdata[30:23]),
    .cfg_i  (cfg_q),
    .vld_o  (fe_vld),
    .dx_o   (fe_dx),
    .side_o (fe_side)
  );

  logic             div_vld;
  logic [QUO_W-1:0] div_quo;
  logic [X_W-1:0]   div_rem;
  side_t            div_side;

  ctb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (fe_vld),
    .dx_i   (fe_dx),
    .side_i (fe_side),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .rem_o  (div_rem),
    .side_o (div_side)
  );

  // Buffer access stage: a write item writes, a pixel item reads its cell
  logic [COL_W-1:0]  col_d;
  logic              e_ok_d;
  logic              ram_we;
  logic              ram_re;
  logic [CODE_W-1:0] ram_rdata;

  always_comb begin
    col_d = '0;
    for (int k = 1; k <= GLYPH_COLS; k++) begin
      if (div_rem >= X_W'(k) * X_W'(div_side.scale)) begin
        col_d = COL_W'(k);
      end
    end
    e_ok_d = div_side.ok && (div_quo < div_side.len) && (col_d < COL_W'(GLYPH_COLS));
    ram_we = pipe_en && div_vld && !div_side.pix && (32'(div_side.idx) < MAX_CHARS);
    ram_re = pipe_en && div_vld && div_side.pix;
  end

  ctb_ram #(
    .WIDTH  (CODE_W),
    .DEPTH  (MAX_CHARS),
    .ADDR_W (ADDR_W)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ADDR_W'(div_side.idx)),
    .wdata_i (div_side.code),
    .re_i    (ram_re),
    .raddr_i (ADDR_W'(div_quo)),
    .rdata_o (ram_rdata)
  );

  logic             e_vld_q;
  logic             e_pix_q;
  logic             e_ok_q;
  logic [ROW_W-1:0] e_row_q;
  logic [COL_W-1:0] e_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (pipe_en) begin
      e_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      e_pix_q <= div_side.pix;
      e_ok_q  <= e_ok_d;
      e_row_q <= div_side.row;
      e_col_q <= col_d;
    end
  end

  // Font lookup on the read code
  logic [CODE_W-1:0]  code;
  glyph_t             glyph;
  logic [7:0]         col_byte;
  logic               hit;
  logic [COLOR_W-1:0] color;
  logic               res_new;

  always_comb begin
    code = ram_rdata;
    if (code < CODE_FIRST || code > CODE_LAST) begin
      code = CODE_SUBST;
    end
    glyph = font_glyph(7'(code - CODE_FIRST));
    case (e_col_q)
      3'd0:    col_byte = glyph[39:32];
      3'd1:    col_byte = glyph[31:24];
      3'd2:    col_byte = glyph[23:16];
      3'd3:    col_byte = glyph[15:8];
      3'd4:    col_byte = glyph[7:0];
      default: col_byte = '0;
    endcase
    hit     = e_ok_q && col_byte[e_row_q];
    color   = hit ? cfg_q.ink_color : cfg_q.paper_color;
    res_new = pipe_en && e_vld_q && e_pix_q;
  end

  // Output register with skid
  logic               out_vld_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_hit_q;
  logic [COLOR_W-1:0] skd_color_q;
  logic               skd_hit_q;
  logic               out_take;

  assign out_take = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else if (out_take) begin
      out_vld_q <= skd_vld_q || res_new;
      skd_vld_q <= 1'b0;
    end else if (res_new) begin
      skd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      if (skd_vld_q) begin
        out_color_q <= skd_color_q;
        out_hit_q   <= skd_hit_q;
      end else begin
        out_color_q <= color;
        out_hit_q   <= hit;
      end
    end else if (res_new) begin
      skd_color_q <= color;
      skd_hit_q   <= hit;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_color_q;
  assign m_axis_tuser  = out_hit_q;

  `CTB_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skd_vld_q, out_vld_q,
    "skid register holds an item while the output register is empty")
  `CTB_ASSERT_NXT(a_skid_drains, clk_i, rst_ni, out_vld_q && m_axis_tready, !skd_vld_q,
    "skid register still occupied after the output item was taken")
  `CTB_ASSERT_IMP(a_hit_is_ink, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
    m_axis_tdata == cfg_q.ink_color, "glyph hit delivered without the ink colour")

endmodule

// ===== design/ctb_ram.sv =====
// ---------------------------------------------------------------------------
// Generic two-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ctb_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/ctb_front.sv =====
// ---------------------------------------------------------------------------
// Text bar rasteriser front end
// Three stages: bar bounds and text width, text placement and font row, offset into the text.
// ---------------------------------------------------------------------------
module ctb_front import ctb_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic              pix_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [CODE_W-1:0] code_i,
  input  logic [X_W-1:0]    x_i,
  input  logic [Y_W-1:0]    y_i,
  input  cfg_t              cfg_i,
  output logic              vld_o,
  output logic [X_W-1:0]    dx_o,
  output side_t             side_o
);

  // Stage A
  logic [SCALE_W-1:0] scale_d;
  logic [LEN_W-1:0]   len_d;
  logic [CELLW_W-1:0] cellw_d;
  logic [WIDTH_W-1:0] width_d;
  logic [X_W:0]       bar_end;
  logic               in_bar;
  logic               a_ok_d;
  logic [Y_W-1:0]     dy_d;

  logic               a_vld_q;
  logic               a_pix_q;
  logic [IDX_W-1:0]   a_idx_q;
  logic [CODE_W-1:0]  a_code_q;
  logic [X_W-1:0]     a_x_q;
  logic [Y_W-1:0]     a_dy_q;
  logic               a_ok_q;
  logic [SCALE_W-1:0] a_scale_q;
  logic [LEN_W-1:0]   a_len_q;
  logic [CELLW_W-1:0] a_cellw_q;
  logic [WIDTH_W-1:0] a_width_q;

  always_comb begin
    scale_d = (cfg_i.glyph_scale == '0) ? SCALE_W'(1) : cfg_i.glyph_scale;
    if (32'(cfg_i.text_length) > MAX_CHARS) begin
      len_d = LEN_W'(MAX_CHARS);
    end else begin
      len_d = cfg_i.text_length;
    end
    cellw_d = CELLW_W'({scale_d, 2'b00}) + CELLW_W'({scale_d, 1'b0});
    width_d = WIDTH_W'(len_d) * WIDTH_W'(cellw_d);
    bar_end = {1'b0, cfg_i.bar_left} + {1'b0, cfg_i.bar_span};
    in_bar  = (x_i >= cfg_i.bar_left) && ({1'b0, x_i} < bar_end);
    a_ok_d  = pix_i && in_bar && (y_i >= cfg_i.text_top);
    dy_d    = y_i - cfg_i.text_top;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_pix_q   <= pix_i;
      a_idx_q   <= idx_i;
      a_code_q  <= code_i;
      a_x_q     <= x_i;
      a_dy_q    <= dy_d;
      a_ok_q    <= a_ok_d;
      a_scale_q <= scale_d;
      a_len_q   <= len_d;
      a_cellw_q <= cellw_d;
      a_width_q <= width_d;
    end
  end

  // Stage B
  logic [X_W-1:0]     slack;
  logic [START_W-1:0] start_d;
  logic [ROW_W-1:0]   row_d;
  logic               b_ok_d;

  logic               b_vld_q;
  logic               b_pix_q;
  logic [IDX_W-1:0]   b_idx_q;
  logic [CODE_W-1:0]  b_code_q;
  logic [X_W-1:0]     b_x_q;
  logic               b_ok_q;
  logic [ROW_W-1:0]   b_row_q;
  logic [SCALE_W-1:0] b_scale_q;
  logic [LEN_W-1:0]   b_len_q;
  logic [CELLW_W-1:0] b_cellw_q;
  logic [WIDTH_W-1:0] b_width_q;
  logic [START_W-1:0] b_start_q;

  always_comb begin
    slack = '0;
    // Clamp to the left edge when the text does not fit
    if (a_width_q >= WIDTH_W'(cfg_i.bar_span)) begin
      start_d = START_W'(cfg_i.bar_left);
    end else begin
      slack   = X_W'(WIDTH_W'(cfg_i.bar_span) - a_width_q);
      start_d = START_W'(cfg_i.bar_left) + START_W'(slack >> 1);
    end
    // Font row by comparison against multiples of the scale
    row_d = '0;
    for (int k = 1; k < GLYPH_ROWS; k++) begin
      if (a_dy_q >= Y_W'(k) * Y_W'(a_scale_q)) begin
        row_d = ROW_W'(k);
      end
    end
    b_ok_d = a_ok_q && (a_dy_q < Y_W'(GLYPH_ROWS) * Y_W'(a_scale_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_pix_q   <= a_pix_q;
      b_idx_q   <= a_idx_q;
      b_code_q  <= a_code_q;
      b_x_q     <= a_x_q;
      b_ok_q    <= b_ok_d;
      b_row_q   <= row_d;
      b_scale_q <= a_scale_q;
      b_len_q   <= a_len_q;
      b_cellw_q <= a_cellw_q;
      b_width_q <= a_width_q;
      b_start_q <= start_d;
    end
  end

  // Stage C
  logic [END_W-1:0] text_end;
  logic             in_text;
  logic [X_W-1:0]   dx_d;
  side_t            side_d;
  logic             c_vld_q;
  logic [X_W-1:0]   c_dx_q;
  side_t            c_side_q;

  always_comb begin
    text_end     = END_W'(b_start_q) + END_W'(b_width_q);
    in_text      = (START_W'(b_x_q) >= b_start_q) && (END_W'(b_x_q) < text_end);
    dx_d         = X_W'(START_W'(b_x_q) - b_start_q);
    side_d.pix   = b_pix_q;
    side_d.ok    = b_ok_q && in_text;
    side_d.row   = b_row_q;
    side_d.scale = b_scale_q;
    side_d.len   = b_len_q;
    side_d.cellw = b_cellw_q;
    side_d.idx   = b_idx_q;
    side_d.code  = b_code_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_dx_q   <= dx_d;
      c_side_q <= side_d;
    end
  end

  assign vld_o  = c_vld_q;
  assign dx_o   = c_dx_q;
  assign side_o = c_side_q;

endmodule

// ===== design/ctb_div.sv =====
// ---------------------------------------------------------------------------
// Text bar rasteriser cell divider
// Restoring division of the text offset by the cell width, one quotient
// bit per stage; the remainder is the offset inside the cell.
// ---------------------------------------------------------------------------
module ctb_div import ctb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [X_W-1:0]   dx_i,
  input  side_t            side_i,
  output logic             vld_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [X_W-1:0]   rem_o,
  output side_t            side_o
);

  logic [QUO_W-1:0] vld_q;
  logic [X_W-1:0]   rem_q  [QUO_W];
  logic [QUO_W-1:0] quo_q  [QUO_W];
  side_t            side_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int Bit = QUO_W - 1 - s;

    logic             vld_in;
    logic [X_W-1:0]   rem_in;
    logic [QUO_W-1:0] quo_in;
    side_t            side_in;
    logic [DIV_W-1:0] dsr;
    logic             fits;
    logic [X_W-1:0]   rem_d;
    logic [QUO_W-1:0] quo_d;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = dx_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      dsr        = DIV_W'(side_in.cellw) << Bit;
      fits       = DIV_W'(rem_in) >= dsr;
      rem_d      = fits ? X_W'(DIV_W'(rem_in) - dsr) : rem_in;
      quo_d      = quo_in;
      quo_d[Bit] = fits;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QUO_W-1];
  assign quo_o  = quo_q[QUO_W-1];
  assign rem_o  = rem_q[QUO_W-1];
  assign side_o = side_q[QUO_W-1];

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Text bar pixel generator testbench
// Drives character writes and pixel requests into the stream input, predicts
// every pixel colour from a shadow text buffer, register set and font, and
// checks each result in order. Register settings change between phases while
// the block is idle; both stream sides idle in random bursts.
// ---------------------------------------------------------------------------
module tb import ctb_pkg::*; ();

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_PRINTS   = 100;
  localparam int TEXT_SLOTS   = 64;
  localparam int CELL_COLS    = 6;
  localparam int FONT_COLS    = 5;
  localparam int FONT_ROWS    = 7;
  localparam int RAND_PHASES  = 14;
  localparam int PHASE_ITEMS  = 100;

  localparam logic [7:0] PRINT_FIRST = 8'h20;
  localparam logic [7:0] PRINT_LAST  = 8'h7E;
  localparam logic [7:0] SUBST_CHAR  = 8'h3F;

  typedef enum bit {
    REQ_CHAR  = 1'b0,
    REQ_PIXEL = 1'b1
  } req_e;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               hit;
  } pixel_t;

  // 95 printable glyphs, first glyph in the top bits; per glyph the leftmost
  // column sits in the top byte and bit 0 of each byte is the top row
  localparam logic [40*95-1:0] FONT_BITS = {
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [DATA_IN_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [COLOR_W-1:0]    m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // Shadow state of the block
  cfg_t       bar_cfg;
  logic [7:0] text_mem [TEXT_SLOTS];
  pixel_t     pixel_queue [$];

  bit tx_idle_en;
  bit rx_idle_en;
  int hold_req;
  int mismatch_cnt;
  int pixels_checked;
  int hits_seen;
  int items_sent;
  int phases_run;
  int cycle_cnt;

  centered_text_bar_pixel_generator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned eff_scale();
    return (bar_cfg.glyph_scale == '0) ? 1 : int'(bar_cfg.glyph_scale);
  endfunction

  function automatic int unsigned eff_length();
    return (bar_cfg.text_length > TEXT_SLOTS) ? TEXT_SLOTS : int'(bar_cfg.text_length);
  endfunction

  function automatic int unsigned text_width();
    return eff_length() * CELL_COLS * eff_scale();
  endfunction

  // Clamp to the bar's left edge when the text does not fit
  function automatic int unsigned text_start();
    int unsigned left, span, wid;
    left = 32'(bar_cfg.bar_left);
    span = 32'(bar_cfg.bar_span);
    wid  = text_width();
    if (wid >= span) return left;
    return left + (span - wid) / 2;
  endfunction

  function automatic bit font_dot(logic [7:0] code, int unsigned fcol, int unsigned frow);
    logic [7:0]  ch;
    logic [39:0] glyph;
    logic [7:0]  dots;
    ch = code;
    if (ch < PRINT_FIRST || ch > PRINT_LAST) ch = SUBST_CHAR;
    if (fcol >= FONT_COLS || frow >= FONT_ROWS) return 1'b0;
    glyph = FONT_BITS[40*(94 - int'(ch - PRINT_FIRST)) +: 40];
    dots  = glyph[8*(4 - fcol) +: 8];
    return dots[frow];
  endfunction

  function automatic bit glyph_at(int unsigned x, int unsigned y);
    int unsigned sc, len, wid, st, left, top, frow, offs, slot, fcol;
    sc   = eff_scale();
    len  = eff_length();
    wid  = text_width();
    left = 32'(bar_cfg.bar_left);
    top  = 32'(bar_cfg.text_top);
    if (x < left || x >= left + int'(bar_cfg.bar_span)) return 1'b0;
    if (y < top) return 1'b0;
    frow = (y - top) / sc;
    if (frow >= FONT_ROWS) return 1'b0;
    st = text_start();
    if (x < st || x >= st + wid) return 1'b0;
    offs = (x - st) / sc;
    slot = offs / CELL_COLS;
    fcol = offs % CELL_COLS;
    if (slot >= len) return 1'b0;
    return font_dot(text_mem[slot], fcol, frow);
  endfunction

  // ------------------------------------------------------------------ checker
  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS)
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixel_queue.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 32'(m_axis_tdata));
      end else begin
        want = pixel_queue.pop_front();
        pixels_checked++;
        if (want.hit) hits_seen++;
        if (m_axis_tdata !== want.color)
          report_mismatch("pixel_color", 32'(want.color), 32'(m_axis_tdata));
        if (m_axis_tuser !== want.hit)
          report_mismatch("glyph_hit", 32'(want.hit), 32'(m_axis_tuser));
      end
    end
  end

  // Result side: random stall bursts, plus a long hold-off on request
  initial begin : result_ready
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall = $urandom_range(1, 13) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------- driver
  task automatic send_req(req_e req, logic [IDX_W-1:0] idx, logic [7:0] code,
                          logic [X_W-1:0] x, logic [Y_W-1:0] y);
    int gap;
    bit hit;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 13);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {1'b0, y, x, code, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (req == REQ_CHAR) begin
      text_mem[idx] = code;
    end else begin
      hit = glyph_at(32'(x), 32'(y));
      pixel_queue.push_back('{color: hit ? bar_cfg.ink_color : bar_cfg.paper_color,
                              hit: hit});
    end
  endtask

  task automatic send_char(int unsigned idx, int unsigned code);
    send_req(REQ_CHAR, idx[IDX_W-1:0], code[7:0], X_W'($urandom_range(0, 511)),
             Y_W'($urandom_range(0, 255)));
  endtask

  task automatic send_pixel(int unsigned x, int unsigned y);
    send_req(REQ_PIXEL, IDX_W'($urandom_range(0, 63)), CODE_W'($urandom_range(0, 255)),
             x[X_W-1:0], y[Y_W-1:0]);
  endtask

  // Drop valid, wait for every pending pixel, then let the pipeline empty
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_register(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_BAR_LEFT:    bar_cfg.bar_left    = val[X_W-1:0];
      CFG_BAR_SPAN:    bar_cfg.bar_span    = val[X_W-1:0];
      CFG_TEXT_TOP:    bar_cfg.text_top    = val[Y_W-1:0];
      CFG_GLYPH_SCALE: bar_cfg.glyph_scale = val[SCALE_W-1:0];
      CFG_TEXT_LENGTH: bar_cfg.text_length = val[LEN_W-1:0];
      CFG_INK_COLOR:   bar_cfg.ink_color   = val;
      CFG_PAPER_COLOR: bar_cfg.paper_color = val;
      default: ;
    endcase
  endtask

  task automatic program_bar(int unsigned left, int unsigned span, int unsigned top,
                             int unsigned scale, int unsigned len, int unsigned ink,
                             int unsigned paper);
    drain_results();
    set_register(CFG_BAR_LEFT, left[15:0]);
    set_register(CFG_BAR_SPAN, span[15:0]);
    set_register(CFG_TEXT_TOP, top[15:0]);
    set_register(CFG_GLYPH_SCALE, scale[15:0]);
    set_register(CFG_TEXT_LENGTH, len[15:0]);
    set_register(CFG_INK_COLOR, ink[15:0]);
    set_register(CFG_PAPER_COLOR, paper[15:0]);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    phases_run++;
  endtask

  function automatic int unsigned pick_code();
    if ($urandom_range(0, 4) != 0) return $urandom_range(32'(PRINT_FIRST), 32'(PRINT_LAST));
    return $urandom_range(0, 255);
  endfunction

  // Aim most pixels at the text block and its rim
  task automatic rand_pixel();
    int unsigned sc, wid, st;
    int xi, yi;
    sc  = eff_scale();
    wid = text_width();
    st  = text_start();
    if ($urandom_range(0, 9) < 8) begin
      xi = int'(st) + int'($urandom_range(0, wid + 2 * sc)) - int'(sc);
      yi = int'(bar_cfg.text_top) + int'($urandom_range(0, 8 * sc)) - 1;
    end else begin
      xi = $urandom_range(0, 511);
      yi = $urandom_range(0, 255);
    end
    send_pixel(xi[X_W-1:0], yi[Y_W-1:0]);
  endtask

  task automatic rand_item();
    if ($urandom_range(0, 99) < 12) send_char($urandom_range(0, TEXT_SLOTS - 1), pick_code());
    else rand_pixel();
  endtask

  // -------------------------------------------------------------------- tests
  // Every slot is written first so no pixel ever reads an unwritten entry
  task automatic test_fill_text();
    for (int i = 0; i < TEXT_SLOTS; i++) send_char(i, pick_code());
    drain_results();
  endtask

  task automatic test_directed();
    int unsigned st;
    // Empty text at reset settings
    send_pixel(100, 195);
    // Codes below and above the printable range, both range ends, top slot
    send_char(0, 'h00);
    send_char(1, 'h7F);
    send_char(2, 'h20);
    send_char(3, 'h7E);
    send_char(4, 'hFF);
    send_char(63, 'h41);
    program_bar(4, 312, 191, 2, 5, 'hF800, 'h001F);
    st = text_start();
    for (int k = 0; k < 10; k++) send_pixel(st + k * 6 + 1, 191 + 7);
    send_pixel(0, 198);
    send_pixel(511, 255);
    // Text wider than the bar starts at its left edge
    program_bar(4, 312, 191, 8, 10, 'h07E0, 'hFFFF);
    send_pixel(3, 191);
    send_pixel(4 + 8, 191 + 8);
    send_pixel(315, 191 + 8);
    send_pixel(316, 191 + 8);
    // Scale of zero and a length past the buffer size
    program_bar(0, 320, 0, 0, 127, 'h0000, 'hFFFF);
    send_pixel(0, 0);
    send_pixel(64 * 6 - 1, 3);
    send_pixel(100, 6);
    program_bar(0, 511, 20, 15, 64, 'hAAAA, 'h5555);
    send_pixel(15, 20 + 15 * 3);
    send_pixel(45, 20 + 15 * 6 + 14);
  endtask

  task automatic test_random_phases();
    int unsigned left, span, top, scale, len, fit;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      case (ph)
        0: program_bar(0, 320, 0, 1, 64, 'h0000, 'hFFFF);
        1: program_bar(511, 511, 255, 15, 127, 'hFFFF, 'h0000);
        2: program_bar(319, 1, 239, 8, 1, 'h1234, 'hFEDC);
        3: program_bar(0, 0, 100, 1, 10, 'hFFFF, 'h0000);
        default: begin
          left  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 319);
          span  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 320);
          top   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 239);
          scale = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
          fit   = span / (6 * ((scale == 0) ? 1 : scale));
          if (fit > TEXT_SLOTS) fit = TEXT_SLOTS;
          if ($urandom_range(0, 1) == 0) len = $urandom_range(0, fit);
          else if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 127);
          else len = $urandom_range(0, TEXT_SLOTS);
          program_bar(left, span, top, scale, len, $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
        end
      endcase
      repeat (PHASE_ITEMS) rand_item();
    end
  endtask

  // Receiver holds off while pixels keep coming, so the input stalls
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    program_bar(40, 240, 60, 3, 12, 'hF81F, 'h0841);
    hold_req = 200;
    repeat (60) rand_pixel();
    drain_results();
  endtask

  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    program_bar(4, 312, 191, 2, 26, 'hFFFF, 'h0000);
    repeat (250) rand_item();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = CFG_BAR_LEFT;
    cfg_wdata_i   = '0;
    bar_cfg       = CFG_RST;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    hold_req      = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_fill_text();
    test_directed();
    test_random_phases();
    test_backpressure();
    test_full_rate();
    drain_results();

    $display("Run covered %0d items over %0d register settings, stalls on both sides.",
             items_sent, phases_run);
    $display("%0d pixels compared, %0d of them on glyph ink.", pixels_checked, hits_seen);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
